// ===== rtl/tsfc_pkg.sv =====
// Shared types and constants of the touch sample filter and calibration core.
// Used by the top level and by the iterative divider; depends on nothing.

package tsfc_pkg;

  // One raw panel sample.
  typedef struct packed {
    logic               pos_valid;
    logic               pen_contact;
    logic signed [15:0] x_minus;
    logic signed [15:0] x_plus;
    logic signed [15:0] y_minus;
    logic signed [15:0] y_plus;
    logic signed [15:0] pressure_raw;
  } tsfc_in_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_PEN_UP = 2'd1,
    ST_POS    = 2'd2
  } tsfc_status_e;

  // One report.
  typedef struct packed {
    tsfc_status_e       status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pressure;
  } tsfc_out_t;

  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_COEF_A       = 3'd0,
    REG_COEF_B       = 3'd1,
    REG_COEF_C       = 3'd2,
    REG_COEF_D       = 3'd3,
    REG_COEF_E       = 3'd4,
    REG_COEF_F       = 3'd5,
    REG_COEF_S       = 3'd6,
    REG_MIN_PRESSURE = 3'd7
  } tsfc_reg_e;

  // Largest position change between two accepted samples.
  localparam logic signed [17:0] JumpLimit = 18'sd360;
  // Hysteresis slop in quarter pixels.
  localparam logic signed [32:0] Slop = 33'sd3;
  // Filter gain of eight as a left shift.
  localparam int unsigned GainShift = 3;

  // Divider step counts: full 64-bit dividend, or the 35-bit filter dividend.
  localparam int unsigned DivSteps      = 64;
  localparam int unsigned DivShortSteps = 35;
  localparam int unsigned DivCntW       = 6;

  // Request to the shared divider.
  typedef struct packed {
    logic start;
    logic short_mode;
  } tsfc_div_req_t;

endpackage

// ===== rtl/tsfc_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tsfc_pkg for the request type and step counts.

module tsfc_div
  import tsfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsfc_div_req_t      req_i,
  input  logic signed [63:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic        [31:0] quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic               neg_q;
  logic [31:0]        den_q;
  logic [31:0]        rem_q;
  logic [63:0]        quo_q;

  logic [63:0] mag_n;
  logic [31:0] mag_d;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic [63:0] quo_signed;

  always_comb begin
    mag_n      = dividend_i[63] ? (~dividend_i + 64'd1) : dividend_i;
    mag_d      = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
    shifted    = {rem_q, quo_q[63]};
    trial      = shifted - {1'b0, den_q};
    quo_signed = neg_q ? (~quo_q + 64'd1) : quo_q;
  end

  assign done_o = done_q;
  assign quot_o = quo_signed[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_mode ? DivCntW'(DivShortSteps - 1) : DivCntW'(DivSteps - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // A short request left-aligns the narrow dividend so fewer steps cover it.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= dividend_i[63] ^ divisor_i[31];
      den_q <= mag_d;
      rem_q <= '0;
      quo_q <= req_i.short_mode ? (mag_n << (DivSteps - DivShortSteps)) : mag_n;
    end else if (busy_q) begin
      rem_q <= trial[32] ? shifted[31:0] : trial[31:0];
      quo_q <= {quo_q[62:0], ~trial[32]};
    end
  end

endmodule

// ===== rtl/touch_sample_filter_calibrate_core.sv =====
// Touch panel sample filter with jump rejection, leaky averaging and affine
// calibration. Depends on tsfc_pkg and the shared divider tsfc_div.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (tsfc_in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (tsfc_out_t)
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Pen up, no position, skip or rejection go from the check straight to the output;
// an unprimed filter only adds the sample to its sums. A filtered report runs the
// divider once per filter lane and, with calibration, once per axis unless the
// divisor is zero; the one-bit-per-cycle divider, used up to five times per
// report, sets the length of a report. Reset restores the register
// defaults and clears the filter. The input is stalled while a sample is in
// work; a report waits in the output register while the next sample is taken,
// and output stall on a waiting report holds the next report back.

module touch_sample_filter_calibrate_core
  import tsfc_pkg::*;
#(
  parameter int unsigned FILTER_SHIFT = 2,
  parameter bit          TRANSFORM_ON = 1'b1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsfc_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsfc_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned FillW = FILTER_SHIFT + 1;
  localparam int unsigned Depth = 1 << FILTER_SHIFT;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FEED,
    S_FDIV,
    S_FWAIT,
    S_MUL_A,
    S_MUL_B,
    S_ADD_P,
    S_ADD_C,
    S_CDIV,
    S_CWAIT,
    S_HYST,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q, coef_f_q, coef_s_q;
  logic signed [15:0] min_pres_q;

  // Filter and hysteresis state.
  logic               skip_q;
  logic               have_prev_q;
  logic signed [16:0] prev_x_q, prev_y_q;
  logic signed [31:0] acc_x_q, acc_y_q, acc_z_q;
  logic [FillW-1:0]   fill_q;
  logic signed [31:0] held_x_q, held_y_q;

  // Work registers.
  tsfc_in_t           in_q;
  tsfc_status_e       status_q;
  logic [1:0]         lane_q;
  logic               axis_q;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic signed [63:0] prod_q, sum_q;
  logic signed [31:0] cal_q;

  logic      out_valid_q;
  tsfc_out_t out_q;

  // Datapath.
  logic signed [16:0] dx, dy;
  logic signed [17:0] jx, jy;
  logic               jump, low_press;
  logic signed [31:0] acc_sel;
  logic signed [31:0] g1, g2, offset, held_sel;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [32:0] hdiff;
  logic               hmove;
  logic               out_free;

  tsfc_div_req_t      div_req;
  logic signed [63:0] div_dividend;
  logic signed [31:0] div_divisor;
  logic               div_done;
  logic [31:0]        div_quot;

  always_comb begin
    dx        = {in_q.x_plus[15], in_q.x_plus} - {in_q.x_minus[15], in_q.x_minus};
    dy        = {in_q.y_plus[15], in_q.y_plus} - {in_q.y_minus[15], in_q.y_minus};
    jx        = {dx[16], dx} - {prev_x_q[16], prev_x_q};
    jy        = {dy[16], dy} - {prev_y_q[16], prev_y_q};
    jump      = have_prev_q && (jx > JumpLimit || jx < -JumpLimit ||
                                jy > JumpLimit || jy < -JumpLimit);
    low_press = in_q.pressure_raw <= min_pres_q;

    case (lane_q)
      2'd0:    acc_sel = acc_x_q;
      2'd1:    acc_sel = acc_y_q;
      default: acc_sel = acc_z_q;
    endcase

    g1       = axis_q ? coef_d_q : coef_a_q;
    g2       = axis_q ? coef_e_q : coef_b_q;
    offset   = axis_q ? coef_f_q : coef_c_q;
    held_sel = axis_q ? held_y_q : held_x_q;

    // One multiplier serves both products of an axis: u is filtered y, v filtered x.
    mul_a = (state_q == S_MUL_A) ? g1 : g2;
    mul_b = (state_q == S_MUL_A) ? oy_q : ox_q;
    mul_p = mul_a * mul_b;

    hdiff = {cal_q[31], cal_q} - {held_sel[31], held_sel};
    hmove = hdiff >= Slop || hdiff <= -Slop;

    div_req.start      = (state_q == S_FDIV) || (state_q == S_CDIV && coef_s_q != '0);
    div_req.short_mode = (state_q == S_FDIV);
    div_dividend = (state_q == S_FDIV) ?
                   {{(64 - 32 - GainShift){acc_sel[31]}}, acc_sel, {GainShift{1'b0}}} :
                   sum_q;
    div_divisor  = (state_q == S_FDIV) ? {{(32 - FillW){1'b0}}, fill_q} : coef_s_q;

    out_free = !out_valid_q || !out_stall_i;
  end

  tsfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= 32'sd4;
      coef_b_q   <= '0;
      coef_c_q   <= '0;
      coef_d_q   <= '0;
      coef_e_q   <= 32'sd4;
      coef_f_q   <= '0;
      coef_s_q   <= 32'sd1;
      min_pres_q <= 16'sd800;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_A:       coef_a_q   <= cfg_data_i;
        REG_COEF_B:       coef_b_q   <= cfg_data_i;
        REG_COEF_C:       coef_c_q   <= cfg_data_i;
        REG_COEF_D:       coef_d_q   <= cfg_data_i;
        REG_COEF_E:       coef_e_q   <= cfg_data_i;
        REG_COEF_F:       coef_f_q   <= cfg_data_i;
        REG_COEF_S:       coef_s_q   <= cfg_data_i;
        REG_MIN_PRESSURE: min_pres_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_NONE;
      lane_q      <= '0;
      axis_q      <= 1'b0;
      skip_q      <= 1'b0;
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
      fill_q      <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          status_q <= ST_NONE;
          if (!in_q.pos_valid) begin
            if (!in_q.pen_contact) begin
              have_prev_q <= 1'b0;
              fill_q      <= '0;
              acc_x_q     <= '0;
              acc_y_q     <= '0;
              acc_z_q     <= '0;
              skip_q      <= 1'b1;
              status_q    <= ST_PEN_UP;
            end
            state_q <= S_OUT;
          end else if (skip_q) begin
            skip_q  <= 1'b0;
            state_q <= S_OUT;
          end else if (low_press || jump) begin
            state_q <= S_OUT;
          end else begin
            prev_x_q    <= dx;
            prev_y_q    <= dy;
            have_prev_q <= 1'b1;
            // A full filter first drops a 1/Depth share of each sum.
            if (fill_q >= FillW'(Depth)) begin
              acc_x_q <= acc_x_q - (acc_x_q >>> FILTER_SHIFT);
              acc_y_q <= acc_y_q - (acc_y_q >>> FILTER_SHIFT);
              acc_z_q <= acc_z_q - (acc_z_q >>> FILTER_SHIFT);
              fill_q  <= FillW'(Depth - 1);
            end
            state_q <= S_FEED;
          end
        end
        S_FEED: begin
          acc_x_q <= acc_x_q + {{15{dx[16]}}, dx};
          acc_y_q <= acc_y_q + {{15{dy[16]}}, dy};
          acc_z_q <= acc_z_q + {{16{in_q.pressure_raw[15]}}, in_q.pressure_raw};
          fill_q  <= fill_q + 1'b1;
          lane_q  <= '0;
          state_q <= (fill_q == '0) ? S_OUT : S_FDIV;
        end
        S_FDIV: begin
          state_q <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            if (lane_q == 2'd2) begin
              status_q <= ST_POS;
              axis_q   <= 1'b0;
              state_q  <= TRANSFORM_ON ? S_MUL_A : S_OUT;
            end else begin
              lane_q  <= lane_q + 1'b1;
              state_q <= S_FDIV;
            end
          end
        end
        S_MUL_A: state_q <= S_MUL_B;
        S_MUL_B: state_q <= S_ADD_P;
        S_ADD_P: state_q <= S_ADD_C;
        S_ADD_C: state_q <= S_CDIV;
        S_CDIV: begin
          state_q <= (coef_s_q == '0) ? S_HYST : S_CWAIT;
        end
        S_CWAIT: begin
          if (div_done) begin
            state_q <= S_HYST;
          end
        end
        S_HYST: begin
          if (hmove) begin
            if (axis_q) begin
              held_y_q <= {cal_q[31:2], 2'b00};
            end else begin
              held_x_q <= {cal_q[31:2], 2'b00};
            end
          end
          if (axis_q) begin
            state_q <= S_OUT;
          end else begin
            axis_q  <= 1'b1;
            state_q <= S_MUL_A;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.status    <= status_q;
            out_q.pos_x     <= '0;
            out_q.pos_y     <= '0;
            out_q.pressure  <= '0;
            if (status_q == ST_POS) begin
              out_q.pos_x    <= TRANSFORM_ON ? (held_x_q >>> 2) : oy_q;
              out_q.pos_y    <= TRANSFORM_ON ? (held_y_q >>> 2) : ox_q;
              out_q.pressure <= oz_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers of the sample in work.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_FWAIT && div_done) begin
      case (lane_q)
        2'd0:    ox_q <= div_quot;
        2'd1:    oy_q <= div_quot;
        default: oz_q <= div_quot;
      endcase
    end
    if (state_q == S_MUL_A || state_q == S_MUL_B) begin
      prod_q <= mul_p;
    end
    if (state_q == S_MUL_B) begin
      sum_q <= prod_q;
    end else if (state_q == S_ADD_P) begin
      sum_q <= sum_q + prod_q;
    end else if (state_q == S_ADD_C) begin
      sum_q <= sum_q + {{32{offset[31]}}, offset};
    end
    // A zero divisor makes the calibrated value zero.
    if (state_q == S_CDIV && coef_s_q == '0) begin
      cal_q <= '0;
    end else if (state_q == S_CWAIT && div_done) begin
      cal_q <= div_quot;
    end
  end

endmodule
